// File: rtl/box_filter_5x5_stream_macros.svh
// Assertion helpers for box_filter_5x5_stream.sv, the one file that asserts.
`ifndef BOX_FILTER_5X5_STREAM_MACROS_SVH
`define BOX_FILTER_5X5_STREAM_MACROS_SVH

// Check the consequent in the same cycle as the antecedent.
`define BF5S_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define BF5S_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bf5s_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bf5s_pkg;

    localparam int CH_NUM     = 3;
    localparam int PIX_W      = 8;
    localparam int WIN        = 5;
    localparam int NLINES     = 4;
    localparam int LINE_SEL_W = 2;
    localparam int CTR_OFS    = 2;

    localparam int CS_W       = 11;
    localparam int SUM_W      = 13;
    localparam int SUM_MAX    = 6375;
    localparam int ROUND_OFS  = 12;
    localparam int DIV_K      = 5243;
    localparam int DIV_SH     = 17;
    localparam int PROD_W     = 26;

    localparam int IW_W       = 11;
    localparam int IH_W       = 13;
    localparam int M_W        = 5;
    localparam int ROW_W      = 12;
    localparam int COL_OUT_W  = 10;
    localparam int MAX_HEIGHT = 4096;
    localparam int MARGIN_MIN = 2;

    localparam int IW_RST     = 1024;
    localparam int IH_RST     = 1024;
    localparam int MX_RST     = 4;
    localparam int MY_RST     = 5;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 8'd0,
        REG_IMAGE_HEIGHT = 8'd1,
        REG_MARGIN_X     = 8'd2,
        REG_MARGIN_Y     = 8'd3
    } cfg_reg_t;

    typedef logic [PIX_W-1:0] chan_t;
    typedef chan_t [CH_NUM-1:0] pixel_t;
    typedef logic [CH_NUM-1:0][CS_W-1:0] colsum_t;
    typedef logic [CH_NUM-1:0][SUM_W-1:0] sum_t;

    function automatic chan_t round_div25(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0]  biased;
        logic [PROD_W-1:0] prod;
        biased = s + SUM_W'(ROUND_OFS);
        prod   = PROD_W'(biased) * PROD_W'(DIV_K);
        return prod[DIV_SH +: PIX_W];
    endfunction

endpackage

`default_nettype wire

// File: rtl/bf5s_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bf5s_pix_if;
    logic             valid;
    logic             ready;
    logic             frame_start;
    bf5s_pkg::chan_t  pix_r;
    bf5s_pkg::chan_t  pix_g;
    bf5s_pkg::chan_t  pix_b;

    modport source (output valid, frame_start, pix_r, pix_g, pix_b, input ready);
    modport sink   (input valid, frame_start, pix_r, pix_g, pix_b, output ready);
endinterface

interface bf5s_res_if;
    logic                                valid;
    logic                                ready;
    bf5s_pkg::chan_t                     avg_r;
    bf5s_pkg::chan_t                     avg_g;
    bf5s_pkg::chan_t                     avg_b;
    logic [bf5s_pkg::COL_OUT_W-1:0]      centre_col;
    logic [bf5s_pkg::ROW_W-1:0]          centre_row;

    modport source (output valid, avg_r, avg_g, avg_b, centre_col, centre_row,
                    input ready);
    modport sink   (input valid, avg_r, avg_g, avg_b, centre_col, centre_row,
                    output ready);
endinterface

interface bf5s_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [bf5s_pkg::CFG_IDX_W-1:0]    reg_index;
    logic [bf5s_pkg::CFG_DATA_W-1:0]   wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

`default_nettype wire

// File: rtl/bf5s_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bf5s_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata <= mem[addr];
            if (we)
            begin
                mem[addr] <= wdata;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/bf5s_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module bf5s_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              shift,
    input  wire bf5s_pkg::colsum_t d,
    output bf5s_pkg::colsum_t      q
);

    bf5s_pkg::colsum_t col_reg;
    bf5s_pkg::colsum_t col_next;

    always_comb
    begin
        col_next = shift ? d : col_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
        end
    end

    assign q = col_reg;

endmodule

`default_nettype wire

// File: rtl/box_filter_5x5_stream.sv
// Streaming 5x5 box filter over RGB pixels in raster order.
// pixel: one transaction per pixel; frame_start puts that pixel at column 0, row 0.
// cfg: register writes (0 width, 1 height, 2 margin_x, 3 margin_y), always ready;
//      write only while the filter holds no pixel whose result is still pending.
// result: one transaction per window centre inside the margins, carrying the
//      rounded 5x5 mean per channel and the centre column and row.
// Path: the pixel that completes a window passes the stage 1, stage 2, stage 3
//      and output registers (4 pipeline registers) before result.valid rises.
// Throughput: one pixel per clock while pixel.ready is high; each accepted pixel
//      reads all four line-store banks at its column and writes only its row's bank.
// When result stalls, the pipeline stages behind the output register keep
//      filling; pixel.ready falls only once every stage holds a pixel.
// Reset: registers return to 1024 x 1024 with margins 4 and 5, position
//      counters and the 5-cell column-sum chain clear; line stores are not
//      cleared, a fill mark per bank makes columns not yet written read as
//      zero, so pixels are taken right after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "box_filter_5x5_stream_macros.svh"

module box_filter_5x5_stream #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    bf5s_pix_if.sink    pixel,
    bf5s_res_if.source  result,
    bf5s_cfg_if.sink    cfg
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WW     = (COL_W + 1 > bf5s_pkg::IW_W) ? COL_W + 1 : bf5s_pkg::IW_W;
    localparam int CMP_W  = WW + 1;
    localparam int RCMP_W = bf5s_pkg::IH_W + 1;
    localparam int PACK_W = bf5s_pkg::CH_NUM * bf5s_pkg::PIX_W;

    // configuration
    logic [bf5s_pkg::IW_W-1:0] img_w_reg;
    logic [bf5s_pkg::IH_W-1:0] img_h_reg;
    logic [bf5s_pkg::M_W-1:0]  mx_reg;
    logic [bf5s_pkg::M_W-1:0]  my_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_w_reg <= bf5s_pkg::IW_W'(bf5s_pkg::IW_RST);
            img_h_reg <= bf5s_pkg::IH_W'(bf5s_pkg::IH_RST);
            mx_reg    <= bf5s_pkg::M_W'(bf5s_pkg::MX_RST);
            my_reg    <= bf5s_pkg::M_W'(bf5s_pkg::MY_RST);
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.reg_index)
                bf5s_pkg::REG_IMAGE_WIDTH:  img_w_reg <= cfg.wr_data[bf5s_pkg::IW_W-1:0];
                bf5s_pkg::REG_IMAGE_HEIGHT: img_h_reg <= cfg.wr_data[bf5s_pkg::IH_W-1:0];
                bf5s_pkg::REG_MARGIN_X:     mx_reg    <= cfg.wr_data[bf5s_pkg::M_W-1:0];
                bf5s_pkg::REG_MARGIN_Y:     my_reg    <= cfg.wr_data[bf5s_pkg::M_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.ready = 1'b1;

    // effective geometry
    logic [WW-1:0]             iw_ext;
    logic [WW-1:0]             w_eff;
    logic [bf5s_pkg::IH_W-1:0] h_eff;
    logic [bf5s_pkg::M_W-1:0]  mx_eff;
    logic [bf5s_pkg::M_W-1:0]  my_eff;

    always_comb
    begin
        iw_ext = WW'(img_w_reg);
        w_eff  = (img_w_reg == '0 || iw_ext > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : iw_ext;
        h_eff  = (img_h_reg == '0 || img_h_reg > bf5s_pkg::IH_W'(bf5s_pkg::MAX_HEIGHT))
                 ? bf5s_pkg::IH_W'(bf5s_pkg::MAX_HEIGHT) : img_h_reg;
        mx_eff = (mx_reg < bf5s_pkg::M_W'(bf5s_pkg::MARGIN_MIN))
                 ? bf5s_pkg::M_W'(bf5s_pkg::MARGIN_MIN) : mx_reg;
        my_eff = (my_reg < bf5s_pkg::M_W'(bf5s_pkg::MARGIN_MIN))
                 ? bf5s_pkg::M_W'(bf5s_pkg::MARGIN_MIN) : my_reg;
    end

    // pipeline control
    logic s1_v_reg, s2_v_reg, s3_v_reg, out_v_reg;
    logic en1, en2, en3, en_out;
    logic acc;

    assign en_out      = !out_v_reg || result.ready;
    assign en3         = !s3_v_reg || en_out;
    assign en2         = !s2_v_reg || en3;
    assign en1         = !s1_v_reg || en2;
    assign pixel.ready = en1;
    assign acc         = pixel.valid && pixel.ready;

    // position
    logic [COL_W-1:0]           col_reg, col_next;
    logic [bf5s_pkg::ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0]           col_base, col_cur;
    logic [bf5s_pkg::ROW_W-1:0] row_base, row_cur;
    logic [WW-1:0]              col_inc;
    logic [bf5s_pkg::IH_W-1:0]  row_inc;
    logic                       col_wrap;
    logic [COL_W-1:0]           cx;
    logic [bf5s_pkg::ROW_W-1:0] cy;
    logic                       emit;

    always_comb
    begin
        col_base = pixel.frame_start ? '0 : col_reg;
        row_base = pixel.frame_start ? '0 : row_reg;
        col_cur  = (WW'(col_base) >= w_eff) ? '0 : col_base;
        row_cur  = (bf5s_pkg::IH_W'(row_base) >= h_eff) ? '0 : row_base;
        col_inc  = WW'(col_cur) + WW'(1);
        row_inc  = bf5s_pkg::IH_W'(row_cur) + bf5s_pkg::IH_W'(1);
        col_wrap = col_inc >= w_eff;
        col_next = col_wrap ? '0 : col_inc[COL_W-1:0];
        if (col_wrap)
        begin
            row_next = (row_inc >= h_eff) ? '0 : row_inc[bf5s_pkg::ROW_W-1:0];
        end
        else
        begin
            row_next = row_cur;
        end
        cx   = col_cur - COL_W'(bf5s_pkg::CTR_OFS);
        cy   = row_cur - bf5s_pkg::ROW_W'(bf5s_pkg::CTR_OFS);
        emit = (col_cur >= COL_W'(bf5s_pkg::CTR_OFS))
            && (row_cur >= bf5s_pkg::ROW_W'(bf5s_pkg::CTR_OFS))
            && (CMP_W'(cx) >= CMP_W'(mx_eff))
            && (CMP_W'(cx) + CMP_W'(mx_eff) < CMP_W'(w_eff))
            && (RCMP_W'(cy) >= RCMP_W'(my_eff))
            && (RCMP_W'(cy) + RCMP_W'(my_eff) < RCMP_W'(h_eff));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (acc)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // line stores, one bank per line
    bf5s_pkg::pixel_t    in_px;
    bf5s_pkg::pixel_t    line_q [bf5s_pkg::NLINES];
    logic [bf5s_pkg::NLINES-1:0] rd_ok;
    logic [bf5s_pkg::NLINES-1:0] s1_ok_reg;

    assign in_px[0] = pixel.pix_r;
    assign in_px[1] = pixel.pix_g;
    assign in_px[2] = pixel.pix_b;

    for (genvar b = 0; b < bf5s_pkg::NLINES; b++)
    begin : g_line
        logic [PACK_W-1:0] rd_word;
        logic [COL_W:0]    fill_reg;
        logic [COL_W:0]    fill_next;
        logic              wr_en;

        assign wr_en    = acc && (row_cur[bf5s_pkg::LINE_SEL_W-1:0]
                                  == bf5s_pkg::LINE_SEL_W'(b));
        assign rd_ok[b] = ({1'b0, col_cur} < fill_reg);

        // advance the fill mark past the highest column written so far
        always_comb
        begin
            fill_next = fill_reg;
            if (wr_en && !rd_ok[b])
            begin
                fill_next = {1'b0, col_cur} + (COL_W+1)'(1);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                fill_reg <= '0;
            end
            else
            begin
                fill_reg <= fill_next;
            end
        end

        bf5s_ram #(
            .WIDTH (PACK_W),
            .DEPTH (MAX_WIDTH)
        ) u_ram (
            .clk   (clk),
            .en    (acc),
            .we    (wr_en),
            .addr  (col_cur),
            .wdata (in_px),
            .rdata (rd_word)
        );

        assign line_q[b] = s1_ok_reg[b] ? bf5s_pkg::pixel_t'(rd_word) : '0;
    end

    // stage 1: pixel beside the line-store read
    bf5s_pkg::pixel_t           s1_px_reg;
    logic                       s1_emit_reg;
    logic [COL_W-1:0]           s1_cx_reg;
    logic [bf5s_pkg::ROW_W-1:0] s1_cy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (en1)
        begin
            s1_v_reg <= acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_px_reg   <= in_px;
            s1_ok_reg   <= rd_ok;
            s1_emit_reg <= emit;
            s1_cx_reg   <= cx;
            s1_cy_reg   <= cy;
        end
    end

    // new column sum and the cell chain
    bf5s_pkg::colsum_t colsum_new;
    bf5s_pkg::colsum_t cell_q [bf5s_pkg::WIN];
    logic              shift;

    always_comb
    begin
        for (int c = 0; c < bf5s_pkg::CH_NUM; c++)
        begin
            colsum_new[c] = bf5s_pkg::CS_W'(s1_px_reg[c])
                          + bf5s_pkg::CS_W'(line_q[0][c])
                          + bf5s_pkg::CS_W'(line_q[1][c])
                          + bf5s_pkg::CS_W'(line_q[2][c])
                          + bf5s_pkg::CS_W'(line_q[3][c]);
        end
    end

    assign shift = en2 && s1_v_reg;

    for (genvar k = 0; k < bf5s_pkg::WIN; k++)
    begin : g_cell
        bf5s_pkg::colsum_t cell_d;

        if (k == bf5s_pkg::WIN - 1)
        begin : g_head
            assign cell_d = colsum_new;
        end
        else
        begin : g_body
            assign cell_d = cell_q[k+1];
        end

        bf5s_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (shift),
            .d     (cell_d),
            .q     (cell_q[k])
        );
    end

    // stage 2: column entering and column leaving the window
    bf5s_pkg::colsum_t          s2_new_reg;
    bf5s_pkg::colsum_t          s2_drop_reg;
    logic                       s2_emit_reg;
    logic [COL_W-1:0]           s2_cx_reg;
    logic [bf5s_pkg::ROW_W-1:0] s2_cy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else if (en2)
        begin
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            s2_new_reg  <= colsum_new;
            s2_drop_reg <= cell_q[0];
            s2_emit_reg <= s1_emit_reg;
            s2_cx_reg   <= s1_cx_reg;
            s2_cy_reg   <= s1_cy_reg;
        end
    end

    // stage 3: running window sum
    bf5s_pkg::sum_t             sum_reg, sum_next;
    logic                       s3_emit_reg;
    logic [COL_W-1:0]           s3_cx_reg;
    logic [bf5s_pkg::ROW_W-1:0] s3_cy_reg;
    logic                       adv3;

    assign adv3 = en3 && s2_v_reg;

    always_comb
    begin
        for (int c = 0; c < bf5s_pkg::CH_NUM; c++)
        begin
            sum_next[c] = sum_reg[c] + bf5s_pkg::SUM_W'(s2_new_reg[c])
                        - bf5s_pkg::SUM_W'(s2_drop_reg[c]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_v_reg <= 1'b0;
            sum_reg  <= '0;
        end
        else
        begin
            if (en3)
            begin
                s3_v_reg <= s2_v_reg;
            end
            if (adv3)
            begin
                sum_reg <= sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            s3_emit_reg <= s2_emit_reg;
            s3_cx_reg   <= s2_cx_reg;
            s3_cy_reg   <= s2_cy_reg;
        end
    end

    // output register: rounded mean
    bf5s_pkg::pixel_t               avg_reg;
    logic [bf5s_pkg::COL_OUT_W-1:0] ccol_reg;
    logic [bf5s_pkg::ROW_W-1:0]     crow_reg;
    logic                           load_out;

    assign load_out = en_out && s3_v_reg && s3_emit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (en_out)
        begin
            out_v_reg <= s3_v_reg && s3_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            for (int c = 0; c < bf5s_pkg::CH_NUM; c++)
            begin
                avg_reg[c] <= bf5s_pkg::round_div25(sum_reg[c]);
            end
            ccol_reg <= bf5s_pkg::COL_OUT_W'(s3_cx_reg);
            crow_reg <= s3_cy_reg;
        end
    end

    assign result.valid      = out_v_reg;
    assign result.avg_r      = avg_reg[0];
    assign result.avg_g      = avg_reg[1];
    assign result.avg_b      = avg_reg[2];
    assign result.centre_col = ccol_reg;
    assign result.centre_row = crow_reg;

    // window total held by the cell chain
    bf5s_pkg::sum_t cell_total;
    logic           sum_ok;

    always_comb
    begin
        sum_ok = 1'b1;
        for (int c = 0; c < bf5s_pkg::CH_NUM; c++)
        begin
            cell_total[c] = '0;
            for (int k = 0; k < bf5s_pkg::WIN; k++)
            begin
                cell_total[c] = cell_total[c] + bf5s_pkg::SUM_W'(cell_q[k][c]);
            end
            if (sum_reg[c] > bf5s_pkg::SUM_W'(bf5s_pkg::SUM_MAX))
            begin
                sum_ok = 1'b0;
            end
        end
    end

    `BF5S_ASSERT_SAME(a_sum_tracks_cells, !s2_v_reg, sum_reg == cell_total, "sum off chain")
    `BF5S_ASSERT_SAME(a_sum_in_range, 1'b1, sum_ok, "window sum out of range")
    `BF5S_ASSERT_NEXT(a_accept_reaches_s1, acc, s1_v_reg, "accepted pixel lost")

endmodule

`default_nettype wire

// File: sim/box_filter_5x5_stream_tb.sv
`timescale 1ns / 1ps

module box_filter_5x5_stream_tb;
    import bf5s_pkg::*;

    localparam int LINE_LEN      = 1024;
    localparam int MAX_ROWS      = 4096;
    localparam int IDLE_LIMIT    = 5000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 500;
    localparam int REPORT_MAX    = 10;

    typedef struct {
        logic  frame_start;
        chan_t r;
        chan_t g;
        chan_t b;
    } pix_item_t;

    typedef struct {
        chan_t                r;
        chan_t                g;
        chan_t                b;
        logic [COL_OUT_W-1:0] col;
        logic [ROW_W-1:0]     row;
    } avg_item_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    bf5s_pix_if pixel ();
    bf5s_res_if result ();
    bf5s_cfg_if cfg ();

    box_filter_5x5_stream uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pixel),
        .result (result),
        .cfg    (cfg)
    );

    always #10 clk = ~clk;

    // filter state as the block should hold it
    logic [IW_W-1:0] width_cfg;
    logic [IH_W-1:0] height_cfg;
    logic [M_W-1:0]  margin_x_cfg;
    logic [M_W-1:0]  margin_y_cfg;
    pixel_t          line_mem [NLINES][LINE_LEN];
    pixel_t          win_regs [WIN][WIN];
    int unsigned     scan_col;
    int unsigned     scan_row;

    pix_item_t pix_pending [$];
    avg_item_t avg_expected [$];

    int  send_idle_pct;
    int  recv_idle_pct;
    int  hold_requests;
    int  holds_done;
    int  hold_left;
    logic px_taken;

    int mismatches;
    int avgs_checked;
    int pixels_taken;
    int settings_used;
    int stall_cycles;

    avg_item_t want;
    avg_item_t got;

    function automatic void box_average_step(input pix_item_t it);
        int unsigned w, h, mx, my, col, row, cx, cy, sum;
        int          i, j, c;
        pixel_t      px;
        chan_t       mean [3];
        avg_item_t   item;
        w  = width_cfg;
        h  = height_cfg;
        mx = (margin_x_cfg < MARGIN_MIN) ? MARGIN_MIN : margin_x_cfg;
        my = (margin_y_cfg < MARGIN_MIN) ? MARGIN_MIN : margin_y_cfg;
        if (w == 0 || w > LINE_LEN)
            w = LINE_LEN;
        if (h == 0 || h > MAX_ROWS)
            h = MAX_ROWS;
        if (it.frame_start)
        begin
            col = 0;
            row = 0;
        end
        else
        begin
            col = scan_col;
            row = scan_row;
        end
        if (col >= w)
            col = 0;
        if (row >= h)
            row = 0;
        px = {it.b, it.g, it.r};
        for (i = 0; i < WIN; i++)
            for (j = 0; j < WIN - 1; j++)
                win_regs[i][j] = win_regs[i][j + 1];
        for (i = 0; i < NLINES; i++)
            win_regs[i][WIN - 1] = line_mem[(row + i) % NLINES][col];
        win_regs[WIN - 1][WIN - 1] = px;
        line_mem[row % NLINES][col] = px;
        if (col >= CTR_OFS && row >= CTR_OFS)
        begin
            cx = col - CTR_OFS;
            cy = row - CTR_OFS;
            if (cx >= mx && cx + mx < w && cy >= my && cy + my < h)
            begin
                for (c = 0; c < 3; c++)
                begin
                    sum = 0;
                    for (i = 0; i < WIN; i++)
                        for (j = 0; j < WIN; j++)
                            sum += win_regs[i][j][c];
                    mean[c] = chan_t'((sum + ROUND_OFS) / 25);
                end
                item.r   = mean[0];
                item.g   = mean[1];
                item.b   = mean[2];
                item.col = COL_OUT_W'(cx);
                item.row = ROW_W'(cy);
                avg_expected.push_back(item);
            end
        end
        col++;
        if (col >= w)
        begin
            col = 0;
            row++;
            if (row >= h)
                row = 0;
        end
        scan_col = col;
        scan_row = row;
    endfunction

    // pixel driver
    always @(negedge clk)
    begin
        if (!rst_n)
            pixel.valid <= 1'b0;
        else if (!pixel.valid || px_taken)
        begin
            if (pix_pending.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                pixel.valid       <= 1'b1;
                pixel.frame_start <= pix_pending[0].frame_start;
                pixel.pix_r       <= pix_pending[0].r;
                pixel.pix_g       <= pix_pending[0].g;
                pixel.pix_b       <= pix_pending[0].b;
            end
            else
                pixel.valid <= 1'b0;
        end
    end

    // result receiver, with a long hold-off on request
    always @(negedge clk)
    begin
        if (!rst_n)
            result.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            result.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else if (holds_done < hold_requests && result.valid)
        begin
            result.ready <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            holds_done   <= holds_done + 1;
        end
        else
            result.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor: check results, then predict from accepted pixels
    always @(posedge clk)
    begin
        if (!rst_n)
            px_taken <= 1'b0;
        else
        begin
            if (result.valid && result.ready)
            begin
                got.r   = result.avg_r;
                got.g   = result.avg_g;
                got.b   = result.avg_b;
                got.col = result.centre_col;
                got.row = result.centre_row;
                if (avg_expected.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: unexpected average r=%0d g=%0d b=%0d col=%0d row=%0d",
                                 $realtime, got.r, got.g, got.b, got.col, got.row);
                end
                else
                begin
                    want = avg_expected.pop_front();
                    avgs_checked++;
                    if (got.r !== want.r || got.g !== want.g || got.b !== want.b ||
                        got.col !== want.col || got.row !== want.row)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                        begin
                            $display("%0t: average differs: expected r=%0d g=%0d b=%0d %s",
                                     $realtime, want.r, want.g, want.b, "");
                            $display("    col=%0d row=%0d, got r=%0d g=%0d b=%0d col=%0d row=%0d",
                                     want.col, want.row, got.r, got.g, got.b,
                                     got.col, got.row);
                        end
                    end
                end
            end
            if (pixel.valid && pixel.ready)
            begin
                box_average_step(pix_pending.pop_front());
                pixels_taken++;
            end
            px_taken <= pixel.valid && pixel.ready;
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pixel.valid && pixel.ready) || (result.valid && result.ready) ||
                (cfg.valid && cfg.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $realtime, IDLE_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg.valid     <= 1'b1;
        cfg.reg_index <= idx;
        cfg.wr_data   <= data;
        forever
        begin
            @(posedge clk);
            if (cfg.ready)
                break;
        end
        case (idx)
            REG_IMAGE_WIDTH:  width_cfg    = data[IW_W-1:0];
            REG_IMAGE_HEIGHT: height_cfg   = data[IH_W-1:0];
            REG_MARGIN_X:     margin_x_cfg = data[M_W-1:0];
            REG_MARGIN_Y:     margin_y_cfg = data[M_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(input int unsigned w, input int unsigned h,
                                input int unsigned mx, input int unsigned my);
        cfg_write(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
        cfg_write(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        cfg_write(REG_MARGIN_X, CFG_DATA_W'(mx));
        cfg_write(REG_MARGIN_Y, CFG_DATA_W'(my));
        @(negedge clk);
        cfg.valid <= 1'b0;
        settings_used++;
    endtask

    task automatic set_idle(input int phase);
        case (phase % 4)
            0:       begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            1:       begin send_idle_pct = 58; recv_idle_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_idle_pct = 58; end
            default: begin send_idle_pct = 21; recv_idle_pct = 21; end
        endcase
    endtask

    function automatic chan_t pick_chan(input int style, input chan_t base);
        case (style)
            0:       return chan_t'($urandom);
            1:       return $urandom_range(1) ? 8'hFF : 8'h00;
            2:       return base + chan_t'($urandom_range(6)) - 8'd3;
            default: return base;
        endcase
    endfunction

    // raster of n pixels from column 0, row 0; noisy adds stray frame starts
    task automatic push_pixels(input int unsigned n, input bit noisy);
        pix_item_t it;
        int        style;
        chan_t     base_r, base_g, base_b;
        style  = $urandom_range(3);
        base_r = chan_t'($urandom);
        base_g = chan_t'($urandom);
        base_b = chan_t'($urandom);
        for (int unsigned i = 0; i < n; i++)
        begin
            it.frame_start = (i == 0) || (noisy && $urandom_range(79) == 0);
            it.r = pick_chan(style, base_r);
            it.g = pick_chan(style, base_g);
            it.b = pick_chan(style, base_b);
            pix_pending.push_back(it);
        end
    endtask

    task automatic finish_phase();
        while (pix_pending.size() != 0)
            @(posedge clk);
        while (avg_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        pix_item_t   it;
        int          phase;
        int unsigned random_items, w, h, n;

        pixel.valid       = 1'b0;
        pixel.frame_start = 1'b0;
        pixel.pix_r       = '0;
        pixel.pix_g       = '0;
        pixel.pix_b       = '0;
        result.ready      = 1'b0;
        cfg.valid         = 1'b0;
        cfg.reg_index     = REG_IMAGE_WIDTH;
        cfg.wr_data       = '0;
        width_cfg         = IW_W'(IW_RST);
        height_cfg        = IH_W'(IH_RST);
        margin_x_cfg      = M_W'(MX_RST);
        margin_y_cfg      = M_W'(MY_RST);
        scan_col          = 0;
        scan_row          = 0;
        send_idle_pct     = 0;
        recv_idle_pct     = 0;
        hold_requests     = 0;
        holds_done        = 0;
        hold_left         = 0;
        mismatches        = 0;
        avgs_checked      = 0;
        pixels_taken      = 0;
        settings_used     = 0;
        stall_cycles      = 0;
        for (int i = 0; i < NLINES; i++)
            for (int j = 0; j < LINE_LEN; j++)
                line_mem[i][j] = '0;
        for (int i = 0; i < WIN; i++)
            for (int j = 0; j < WIN; j++)
                win_regs[i][j] = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // smallest frame with one centre: saturated red, rounding edge on green
        phase = 0;
        set_idle(phase);
        set_geometry(5, 5, 2, 2);
        for (int i = 0; i < 25; i++)
        begin
            it.frame_start = (i == 0);
            it.r = 8'hFF;
            it.g = (i == 24) ? 8'd13 : 8'd0;
            it.b = (i % 2) ? 8'hFF : 8'h00;
            pix_pending.push_back(it);
        end
        finish_phase();
        phase++;

        // long hold-off on the receiver while the sender keeps offering pixels
        set_idle(0);
        hold_requests++;
        set_geometry(8, 8, 2, 2);
        push_pixels(64, 1'b0);
        finish_phase();

        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            set_idle(phase);
            w = $urandom_range(20, 5);
            h = $urandom_range(16, 5);
            set_geometry(w, h, $urandom_range(4, 2), $urandom_range(4, 2));
            n = w * h * $urandom_range(2, 1) + $urandom_range(w * 3, 0);
            if (n > RANDOM_ITEMS - random_items)
                n = RANDOM_ITEMS - random_items;
            push_pixels(n, 1'b1);
            random_items += n;
            finish_phase();
            phase++;
        end

        // extremes of the geometry
        set_idle(phase++);
        set_geometry(1, 1, 16, 16);
        push_pixels(30, 1'b1);
        finish_phase();

        set_idle(phase++);
        set_geometry(36, 6, 16, 2);
        push_pixels(36 * 6 + 10, 1'b0);
        finish_phase();

        set_idle(phase++);
        set_geometry(5, 35, 2, 16);
        push_pixels(5 * 21, 1'b0);
        finish_phase();

        // margins below two act as two
        set_idle(phase++);
        set_geometry(8, 8, 0, 1);
        push_pixels(64, 1'b0);
        finish_phase();

        // zero width acts as full width
        set_idle(phase++);
        set_geometry(0, 6, 2, 2);
        push_pixels(40, 1'b0);
        finish_phase();

        // zero height acts as full height
        set_idle(phase++);
        set_geometry(LINE_LEN, 0, 16, 2);
        push_pixels(40, 1'b0);
        finish_phase();

        set_idle(phase++);
        set_geometry(5, MAX_ROWS, 2, 16);
        push_pixels(20, 1'b0);
        finish_phase();

        set_idle(phase++);
        set_geometry(12, 1, 3, 2);
        push_pixels(30, 1'b1);
        finish_phase();

        $display("Checked %0d averages from %0d pixels over %0d geometry settings,",
                 avgs_checked, pixels_taken, settings_used);
        $display("widths 1 to %0d, heights 1 to %0d, margins 0 to 16, %s",
                 LINE_LEN, MAX_ROWS, "with stalls and stray frame starts");
        if (mismatches == 0 && avg_expected.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/bf5s_pkg.sv
rtl/bf5s_if.sv
rtl/bf5s_ram.sv
rtl/bf5s_cell.sv
rtl/box_filter_5x5_stream.sv
sim/box_filter_5x5_stream_tb.sv
